@@ src/action_token_scanner_macros.svh @@
// Assertion macros used by the checker file of the scanner.
`ifndef ACTION_TOKEN_SCANNER_MACROS_SVH
`define ACTION_TOKEN_SCANNER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner port check failed");

// The consequent must hold in the cycle after the antecedent.
`define ATS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner port check failed");

`endif

@@ src/ats_pkg.sv @@
package ats_pkg;

    localparam int POSITION_BITS_DEF = 16;

    localparam int CH_W    = 8;
    localparam int KIND_W  = 3;
    localparam int OP_W    = 3;
    localparam int LIT_W   = 64;
    localparam int START_W = 16;
    localparam int LEN_W   = 16;
    localparam int ERR_W   = 3;
    localparam int DIGIT_W = 4;

    localparam int FIELDS_W = OP_W + LIT_W + START_W + LEN_W + ERR_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - FIELDS_W;

    typedef enum logic [3:0] {
        MODE_START = 4'b0001,
        MODE_GAP   = 4'b0010,
        MODE_TOKEN = 4'b0100,
        MODE_SKIP  = 4'b1000
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        CL_SHOW  = 3'd0,
        CL_CALL  = 3'd1,
        CL_REF   = 3'd2,
        CL_GET   = 3'd3,
        CL_CONST = 3'd4,
        CL_OPER  = 3'd5
    } class_t;

    localparam logic [KIND_W-1:0] KIND_NONE = 3'd5;

    localparam logic [OP_W-1:0] OP_SET = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK         = 3'd0;
    localparam logic [ERR_W-1:0] ERR_SHOW_JUNK  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_REF_JUNK   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_GET_JUNK   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_LITERAL    = 3'd4;
    localparam logic [ERR_W-1:0] ERR_UNEXPECTED = 3'd5;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_BANG  = 8'h21;
    localparam logic [CH_W-1:0] CH_AMP   = 8'h26;
    localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_AT    = 8'h40;
    localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [OP_W-1:0]    op;
        logic [LIT_W-1:0]   lit;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic [ERR_W-1:0]   err;
        logic               last;
    } res_t;

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_letter(input logic [CH_W-1:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
    endfunction

    function automatic logic is_decimal(input logic [CH_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // An operand byte maps to its class; anything else maps to CL_OPER.
    function automatic class_t operand_class(input logic [CH_W-1:0] c);
        class_t cls;
        cls = CL_OPER;
        if (c == CH_AT)
        begin
            cls = CL_REF;
        end
        else if (c == CH_AMP)
        begin
            cls = CL_GET;
        end
        else if (is_decimal(c))
        begin
            cls = CL_CONST;
        end
        return cls;
    endfunction

endpackage

@@ src/ats_in_reg.sv @@
module ats_in_reg
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ats_pkg::CH_W-1:0] in_ch,
    input  logic                     take,
    output logic                     valid,
    output logic [ats_pkg::CH_W-1:0] ch
);

    logic                     valid_reg;
    logic                     valid_next;
    logic [ats_pkg::CH_W-1:0] ch_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg <= in_ch;
        end
    end

    assign valid = valid_reg;
    assign ch    = ch_reg;

endmodule

@@ src/ats_scan.sv @@
module ats_scan
#(
    parameter int POSITION_BITS = ats_pkg::POSITION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  logic [ats_pkg::CH_W-1:0] ch,
    output logic                     has_res,
    output ats_pkg::res_t            res
);

    localparam int ACC_X_W = ats_pkg::LIT_W + ats_pkg::DIGIT_W;

    ats_pkg::mode_t                  mode_reg, mode_next;
    ats_pkg::class_t                 class_reg, class_next;
    logic [ats_pkg::OP_W-1:0]        op_reg, op_next;
    logic [ats_pkg::LIT_W-1:0]       acc_reg, acc_next;
    logic                            invalid_reg, invalid_next;
    logic [POSITION_BITS-1:0]        pos_reg, pos_next;
    logic [ats_pkg::START_W-1:0]     start_reg, start_next;
    logic [ats_pkg::LEN_W-1:0]       len_reg, len_next;
    logic [ats_pkg::ERR_W-1:0]       pend_reg, pend_next;

    logic                            at_end;
    logic                            at_space;
    logic [ats_pkg::DIGIT_W-1:0]     digit;
    logic [ACC_X_W-1:0]              acc_ext;
    logic [ACC_X_W-1:0]              acc_x10;
    ats_pkg::class_t                 opnd_cls;
    logic [ats_pkg::ERR_W-1:0]       close_err;

    assign at_end   = (ch == ats_pkg::CH_NUL);
    assign at_space = ats_pkg::is_space(ch);
    assign digit    = ch[ats_pkg::DIGIT_W-1:0];
    assign opnd_cls = ats_pkg::operand_class(ch);

    // Ten times the value plus the new digit, with room to see overflow.
    assign acc_ext  = {{ats_pkg::DIGIT_W{1'b0}}, acc_reg};
    assign acc_x10  = (acc_ext << 3) + (acc_ext << 1)
                    + {{ats_pkg::LIT_W{1'b0}}, digit};

    always_comb
    begin
        close_err = pend_reg;
        if ((close_err == ats_pkg::ERR_OK) && (class_reg == ats_pkg::CL_OPER))
        begin
            close_err = ats_pkg::ERR_UNEXPECTED;
        end
        if ((close_err == ats_pkg::ERR_OK) && (class_reg == ats_pkg::CL_CONST) && invalid_reg)
        begin
            close_err = ats_pkg::ERR_LITERAL;
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        class_next   = class_reg;
        op_next      = op_reg;
        acc_next     = acc_reg;
        invalid_next = invalid_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        pend_next    = pend_reg;
        pos_next     = at_end ? '0 : pos_reg + 1'b1;

        has_res   = 1'b0;
        res.kind  = ats_pkg::KIND_NONE;
        res.op    = ats_pkg::OP_SET;
        res.lit   = '0;
        res.start = ats_pkg::START_W'(pos_reg);
        res.len   = '0;
        res.err   = ats_pkg::ERR_OK;
        res.last  = 1'b1;

        case (mode_reg)
            ats_pkg::MODE_SKIP:
            begin
                if (at_end)
                begin
                    mode_next = ats_pkg::MODE_START;
                end
            end
            ats_pkg::MODE_START,
            ats_pkg::MODE_GAP:
            begin
                if (at_end)
                begin
                    has_res   = 1'b1;
                    mode_next = ats_pkg::MODE_START;
                end
                else if (at_space)
                begin
                    if (mode_reg == ats_pkg::MODE_START)
                    begin
                        // Text that opens with whitespace is rejected outright.
                        has_res   = 1'b1;
                        res.start = '0;
                        res.err   = ats_pkg::ERR_UNEXPECTED;
                        mode_next = ats_pkg::MODE_SKIP;
                    end
                end
                else
                begin
                    mode_next    = ats_pkg::MODE_TOKEN;
                    start_next   = ats_pkg::START_W'(pos_reg);
                    len_next     = ats_pkg::LEN_W'(1);
                    pend_next    = ats_pkg::ERR_OK;
                    invalid_next = 1'b0;
                    acc_next     = '0;
                    op_next      = ats_pkg::OP_SET;
                    class_next   = ats_pkg::CL_OPER;
                    if (ch == ats_pkg::CH_BANG)
                    begin
                        class_next = ats_pkg::CL_SHOW;
                    end
                    else if (ats_pkg::is_letter(ch))
                    begin
                        class_next = ats_pkg::CL_CALL;
                    end
                    else if (ch == ats_pkg::CH_PLUS)
                    begin
                        op_next = ats_pkg::OP_ADD;
                    end
                    else if (ch == ats_pkg::CH_MINUS)
                    begin
                        op_next = ats_pkg::OP_SUB;
                    end
                    else if (ch == ats_pkg::CH_STAR)
                    begin
                        op_next = ats_pkg::OP_MUL;
                    end
                    else if (ch == ats_pkg::CH_SLASH)
                    begin
                        op_next = ats_pkg::OP_DIV;
                    end
                    else if (opnd_cls == ats_pkg::CL_OPER)
                    begin
                        pend_next = ats_pkg::ERR_UNEXPECTED;
                    end
                    else
                    begin
                        class_next = opnd_cls;
                        if (opnd_cls == ats_pkg::CL_CONST)
                        begin
                            acc_next = {{(ats_pkg::LIT_W - ats_pkg::DIGIT_W){1'b0}}, digit};
                        end
                    end
                end
            end
            ats_pkg::MODE_TOKEN:
            begin
                if (at_end || at_space)
                begin
                    has_res   = 1'b1;
                    res.start = start_reg;
                    res.len   = len_reg;
                    if (close_err != ats_pkg::ERR_OK)
                    begin
                        res.err   = close_err;
                        mode_next = at_end ? ats_pkg::MODE_START : ats_pkg::MODE_SKIP;
                    end
                    else
                    begin
                        res.kind  = class_reg;
                        res.op    = (class_reg >= ats_pkg::CL_REF) ? op_reg : ats_pkg::OP_SET;
                        res.lit   = (class_reg == ats_pkg::CL_CONST) ? acc_reg : '0;
                        res.last  = at_end;
                        mode_next = at_end ? ats_pkg::MODE_START : ats_pkg::MODE_GAP;
                    end
                end
                else
                begin
                    if (len_reg != ats_pkg::LEN_MAX)
                    begin
                        len_next = len_reg + 1'b1;
                    end
                    if ((pend_reg == ats_pkg::ERR_OK) && !invalid_reg)
                    begin
                        case (class_reg)
                            ats_pkg::CL_SHOW:
                            begin
                                pend_next = ats_pkg::ERR_SHOW_JUNK;
                            end
                            ats_pkg::CL_REF:
                            begin
                                pend_next = ats_pkg::ERR_REF_JUNK;
                            end
                            ats_pkg::CL_GET:
                            begin
                                pend_next = ats_pkg::ERR_GET_JUNK;
                            end
                            ats_pkg::CL_CONST:
                            begin
                                // Leading zero, non-digit or overflow spoils the literal.
                                if (!ats_pkg::is_decimal(ch) || (acc_reg == '0)
                                    || (acc_x10[ACC_X_W-1:ats_pkg::LIT_W] != '0))
                                begin
                                    invalid_next = 1'b1;
                                end
                                else
                                begin
                                    acc_next = acc_x10[ats_pkg::LIT_W-1:0];
                                end
                            end
                            ats_pkg::CL_OPER:
                            begin
                                if (opnd_cls == ats_pkg::CL_OPER)
                                begin
                                    pend_next = ats_pkg::ERR_UNEXPECTED;
                                end
                                else
                                begin
                                    class_next = opnd_cls;
                                    if (opnd_cls == ats_pkg::CL_CONST)
                                    begin
                                        acc_next = {{(ats_pkg::LIT_W - ats_pkg::DIGIT_W){1'b0}},
                                                    digit};
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                mode_next = ats_pkg::MODE_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= ats_pkg::MODE_START;
            class_reg   <= ats_pkg::CL_SHOW;
            op_reg      <= ats_pkg::OP_SET;
            acc_reg     <= '0;
            invalid_reg <= 1'b0;
            pos_reg     <= '0;
            start_reg   <= '0;
            len_reg     <= '0;
            pend_reg    <= ats_pkg::ERR_OK;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            class_reg   <= class_next;
            op_reg      <= op_next;
            acc_reg     <= acc_next;
            invalid_reg <= invalid_next;
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            len_reg     <= len_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

@@ src/ats_res_reg.sv @@
module ats_res_reg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic          has_res,
    input  ats_pkg::res_t res_in,
    output logic          free,
    output logic          out_valid,
    input  logic          out_ready,
    output ats_pkg::res_t res_out
);

    logic          valid_reg;
    logic          valid_next;
    ats_pkg::res_t res_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load ? has_res : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && has_res)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

@@ src/action_token_scanner.sv @@
// Token scanner for a byte stream: one text byte per item in, at most one token item out per
// byte, taken at a sustained rate of one byte per cycle while the output is not stalled. A
// byte passes an input register, the scan logic and a result register; the multiply-by-ten
// add of the 64-bit literal sets the cycle time. Positions count from zero within each
// zero-terminated text and wrap at 2^POSITION_BITS. After an error item, bytes are dropped
// without items up to and including the zero byte.
module action_token_scanner
#(
    parameter int POSITION_BITS = ats_pkg::POSITION_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ats_pkg::CH_W-1:0]      s_axis_tdata,  // ch
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // operation, literal_value, token_start, token_length, error_code, zero pad
    output logic [ats_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic [ats_pkg::KIND_W-1:0]    m_axis_tuser,  // token_kind
    output logic                          m_axis_tlast
);

    logic                     in_valid;
    logic [ats_pkg::CH_W-1:0] in_ch;
    logic                     out_free;
    logic                     take;
    logic                     has_res;
    ats_pkg::res_t            scan_res;
    ats_pkg::res_t            out_res;

    assign take = in_valid && out_free;

    ats_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_ch    (s_axis_tdata),
        .take     (take),
        .valid    (in_valid),
        .ch       (in_ch)
    );

    ats_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (take),
        .ch      (in_ch),
        .has_res (has_res),
        .res     (scan_res)
    );

    ats_res_reg u_res_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .has_res   (has_res),
        .res_in    (scan_res),
        .free      (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res_out   (out_res)
    );

    assign m_axis_tdata = {{ats_pkg::PAD_W{1'b0}}, out_res.err, out_res.len, out_res.start,
                           out_res.lit, out_res.op};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

@@ src/ats_checker.sv @@
`include "action_token_scanner_macros.svh"

module ats_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [ats_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic [ats_pkg::KIND_W-1:0]  m_axis_tuser,
    input logic                        m_axis_tlast
);

    localparam int LIT_LO = ats_pkg::OP_W;
    localparam int LIT_HI = LIT_LO + ats_pkg::LIT_W - 1;
    localparam int ERR_LO = ats_pkg::OP_W + ats_pkg::LIT_W + ats_pkg::START_W + ats_pkg::LEN_W;
    localparam int ERR_HI = ERR_LO + ats_pkg::ERR_W - 1;

    logic                        out_stall;
    logic                        is_error;
    logic                        not_const;
    logic                        closes_text;
    logic [ats_pkg::ERR_W-1:0]   err_field;
    logic [ats_pkg::LIT_W-1:0]   lit_field;

    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign err_field   = m_axis_tdata[ERR_HI:ERR_LO];
    assign lit_field   = m_axis_tdata[LIT_HI:LIT_LO];
    assign is_error    = err_field != ats_pkg::ERR_OK;
    assign not_const   = m_axis_tuser != ats_pkg::CL_CONST;
    assign closes_text = m_axis_tlast && (m_axis_tuser == ats_pkg::KIND_NONE);

    // With the result register empty, the block always takes a byte.
    `ATS_ASSERT_SAME(a_empty_ready, clk, rst_n, !m_axis_tvalid, s_axis_tready)
    `ATS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    `ATS_ASSERT_SAME(a_error_closes, clk, rst_n, m_axis_tvalid && is_error, closes_text)
    `ATS_ASSERT_SAME(a_literal_only_const, clk, rst_n, m_axis_tvalid && not_const, lit_field == '0)

endmodule

bind action_token_scanner ats_checker u_ats_checker (.*);
